[src/mdf_pkg.sv]
// mdf_pkg: shared constants, types and the crc-16 byte step for the reply deframer
// no dependencies
package mdf_pkg;

	localparam int MAX_FRAME   = 20;
	localparam int OVERHEAD    = 5;
	localparam int MAX_RESULTS = 4;
	localparam int BUF_AW      = $clog2(MAX_FRAME);
	localparam int FILL_W      = $clog2(MAX_FRAME + 1);
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0]  FUNC_READ = 8'h03;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PROC,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic        frame_kind;
		logic [7:0]  function_code;
		logic [15:0] distance;
		logic [3:0]  payload_length;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [BUF_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [BUF_AW-1:0] raddr;
	} ram_req_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[src/modbus_reply_deframer.sv]
// modbus_reply_deframer: top level with address register, output register and the deframer core
// depends on mdf_pkg, mdf_byte_ram and mdf_frame_ctrl
//
// Each accepted word is one received byte. It is appended to a small circular byte
// store, and the controller walks the unread bytes of the store, each with a
// registered read of the store, then parse and crc update. A byte is accepted only
// in idle, and in_stall stays high until the walk and the result flush are done, so
// a new byte is not taken before the last one is through; a dropped frame (too long,
// or bad crc) rewinds the read pointer to the byte after its address and walks the
// stored bytes again. Drops nested inside a replay stack up, and a result can hold
// the walk further while it waits on out_stall. Up to four results come from one
// byte; the last one carries last_of_run. A finished result waits in the output
// register while the next byte is accepted. The address register resets to 1; the
// user must write it with cfg_write while the block is idle, which the block does not enforce.
module modbus_reply_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_kind,
	output logic [7:0]  function_code,
	output logic [15:0] distance,
	output logic [3:0]  payload_length,
	output logic        last_of_run
);
	import mdf_pkg::*;

	logic [7:0] device_address_q;
	ram_req_t   ram_req;
	logic [7:0] ram_rdata;
	logic       out_free, push;
	result_t    push_res, out_q;
	logic       out_valid_q;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 8'd1;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_write) device_address_q <= cfg_data;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) out_q <= push_res;
	end

	mdf_byte_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	mdf_frame_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.device_address (device_address_q),
		.in_valid       (in_valid),
		.in_byte        (rx_byte),
		.in_stall       (in_stall),
		.ram_req        (ram_req),
		.ram_rdata      (ram_rdata),
		.out_free       (out_free),
		.push           (push),
		.push_res       (push_res)
	);

	assign out_valid      = out_valid_q;
	assign frame_kind     = out_q.frame_kind;
	assign function_code  = out_q.function_code;
	assign distance       = out_q.distance;
	assign payload_length = out_q.payload_length;
	assign last_of_run    = out_q.last_of_run;

endmodule

[src/mdf_byte_ram.sv]
// mdf_byte_ram: circular byte store holding the bytes from the current frame start on
// depends on mdf_pkg
module mdf_byte_ram (
	input  logic             clk,
	input  mdf_pkg::ram_req_t req,
	output logic [7:0]       rdata
);
	import mdf_pkg::*;

	logic [7:0] mem [2**BUF_AW];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

[src/mdf_frame_ctrl.sv]
// mdf_frame_ctrl: byte loop over the byte store, frame parse, crc check, replay and result hold
// depends on mdf_pkg and drives one mdf_byte_ram port set
module mdf_frame_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        device_address,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	output logic              in_stall,
	output mdf_pkg::ram_req_t ram_req,
	input  logic [7:0]        ram_rdata,
	input  logic              out_free,
	output logic              push,
	output mdf_pkg::result_t  push_res
);
	import mdf_pkg::*;

	state_t            st_q, st_d;
	logic [BUF_AW-1:0] rd_q, wr_q, base_q;
	logic [FILL_W-1:0] fill_q, exp_q;
	logic              in_frame_q;
	logic [RES_W-1:0]  nres_q;
	logic              held_v_q;
	result_t           held_q;
	logic [15:0]       crc_q;
	logic [7:0]        crc_lo_q, fn_q, len_q, d3_q, d4_q;

	logic       accept, empty;
	logic       is_addr, too_long, done, crc_upd, crc_good, good, rewind, emit, hold_wait;
	logic [8:0] len_total;
	logic [7:0] d4;
	result_t    new_res;

	assign accept = (st_q == ST_IDLE) && in_valid;
	assign empty  = (rd_q == wr_q);

	always_comb begin
		is_addr   = (ram_rdata == device_address);
		len_total = {1'b0, ram_rdata} + 9'(OVERHEAD);
		too_long  = in_frame_q && (fill_q == FILL_W'(2)) && (len_total > 9'(MAX_FRAME));
		done      = in_frame_q && (fill_q >= FILL_W'(3)) && ((fill_q + FILL_W'(1)) == exp_q);
		crc_upd   = (fill_q < FILL_W'(3))
			|| (({1'b0, fill_q} + (FILL_W+1)'(2)) < {1'b0, exp_q});
		crc_good  = (crc_q == {ram_rdata, crc_lo_q});
		good      = done && crc_good;
		rewind    = too_long || (done && !crc_good);
		emit      = good && (nres_q < RES_W'(MAX_RESULTS));
		hold_wait = emit && held_v_q && !out_free;
		d4        = (fill_q == FILL_W'(4)) ? ram_rdata : d4_q;
		new_res.frame_kind     = (fn_q != FUNC_READ);
		new_res.function_code  = fn_q;
		new_res.distance       = (fn_q == FUNC_READ) ? {d3_q, d4} : 16'h0000;
		new_res.payload_length = len_q[3:0];
		new_res.last_of_run    = 1'b0;
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (in_valid) st_d = ST_READ;
			ST_READ:  st_d = empty ? ST_FLUSH : ST_PROC;
			ST_PROC:  if (!hold_wait) st_d = ST_READ;
			ST_FLUSH: if (!held_v_q || out_free) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall      = (st_q != ST_IDLE);
		ram_req.we    = accept;
		ram_req.waddr = wr_q;
		ram_req.wdata = in_byte;
		ram_req.re    = (st_q == ST_READ) && !empty;
		ram_req.raddr = rd_q;
		push          = 1'b0;
		push_res      = held_q;
		case (st_q)
			ST_PROC: begin
				push = emit && held_v_q && out_free;
			end
			ST_FLUSH: begin
				push                 = held_v_q && out_free;
				push_res.last_of_run = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			rd_q       <= '0;
			wr_q       <= '0;
			base_q     <= '0;
			fill_q     <= '0;
			exp_q      <= '0;
			in_frame_q <= 1'b0;
			nres_q     <= '0;
			held_v_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						wr_q   <= wr_q + BUF_AW'(1);
						nres_q <= '0;
					end
				end
				ST_READ: begin
					if (!empty) rd_q <= rd_q + BUF_AW'(1);
				end
				ST_PROC: begin
					if (!hold_wait) begin
						if (in_frame_q) begin
							if (fill_q == FILL_W'(2)) exp_q <= FILL_W'(len_total);
							if (good || rewind) begin
								in_frame_q <= 1'b0;
								fill_q     <= '0;
							end else begin
								fill_q <= fill_q + FILL_W'(1);
							end
							if (rewind) rd_q <= base_q + BUF_AW'(1);
							if (emit) begin
								held_v_q <= 1'b1;
								nres_q   <= nres_q + RES_W'(1);
							end
						end else if (is_addr) begin
							in_frame_q <= 1'b1;
							base_q     <= rd_q - BUF_AW'(1);
							fill_q     <= FILL_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (held_v_q && out_free) held_v_q <= 1'b0;
				end
				default: begin
					held_v_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_PROC && !hold_wait) begin
			crc_lo_q <= ram_rdata;
			if (in_frame_q) begin
				if (crc_upd) crc_q <= crc_byte(crc_q, ram_rdata);
				if (fill_q == FILL_W'(1)) fn_q <= ram_rdata;
				if (fill_q == FILL_W'(2)) len_q <= ram_rdata;
				if (fill_q == FILL_W'(3)) d3_q <= ram_rdata;
				if (fill_q == FILL_W'(4)) d4_q <= ram_rdata;
				if (emit) held_q <= new_res;
			end else if (is_addr) begin
				crc_q <= crc_byte(CRC_INIT, ram_rdata);
			end
		end
	end

endmodule
